### sv/gbsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbsp_pkg
// Shared types and constants for the GIF block stream parser.
// ----------------------------------------------------------------------------
package gbsp_pkg;

    typedef enum logic [4:0] {
        PH_HDR      = 5'd0,
        PH_GCT      = 5'd1,
        PH_INTRO    = 5'd2,
        PH_LABEL    = 5'd3,
        PH_GC       = 5'd4,
        PH_APPSIZE  = 5'd5,
        PH_APPID    = 5'd6,
        PH_SUBLEN   = 5'd7,
        PH_SUBDATA  = 5'd8,
        PH_SKIPLEN  = 5'd9,
        PH_SKIPDATA = 5'd10,
        PH_IMG      = 5'd11,
        PH_LCT      = 5'd12,
        PH_MINCODE  = 5'd13,
        PH_DONE     = 5'd14
    } t_phase;

    localparam logic [4:0] EV_VERSION = 5'd0;
    localparam logic [4:0] EV_SWIDTH  = 5'd1;
    localparam logic [4:0] EV_SHEIGHT = 5'd2;
    localparam logic [4:0] EV_SFLAGS  = 5'd3;
    localparam logic [4:0] EV_BG      = 5'd4;
    localparam logic [4:0] EV_ASPECT  = 5'd5;
    localparam logic [4:0] EV_GCOLOUR = 5'd6;
    localparam logic [4:0] EV_GCTRL   = 5'd7;
    localparam logic [4:0] EV_ILEFT   = 5'd8;
    localparam logic [4:0] EV_IFLAGS  = 5'd12;
    localparam logic [4:0] EV_LCOLOUR = 5'd13;
    localparam logic [4:0] EV_MINCODE = 5'd14;
    localparam logic [4:0] EV_PAYLOAD = 5'd15;
    localparam logic [4:0] EV_APPID   = 5'd16;
    localparam logic [4:0] EV_BLKEND  = 5'd17;
    localparam logic [4:0] EV_TRAILER = 5'd18;
    localparam logic [4:0] EV_ERROR   = 5'd19;

    localparam logic [2:0] ERR_HEADER  = 3'd0;
    localparam logic [2:0] ERR_APPSIZE = 3'd1;
    localparam logic [2:0] ERR_GCSIZE  = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN = 3'd3;
    localparam logic [2:0] ERR_TRUNC   = 3'd4;

    localparam logic [1:0] KIND_IMAGE = 2'd0;
    localparam logic [1:0] KIND_COMMENT = 2'd1;
    localparam logic [1:0] KIND_TEXT  = 2'd2;
    localparam logic [1:0] KIND_APP   = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [4:0]  event_res;
        logic [23:0] value;
        logic [7:0]  index;
        logic [1:0]  block_kind;
        logic [2:0]  disposal;
        logic        user_input;
        logic        transparency;
        logic        interlace;
        logic        has_control;
        logic [2:0]  error_code;
    } t_result;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_item;

endpackage

### sv/gif_block_stream_parser.sv
`timescale 1ns / 1ps
// Path: a byte is registered in the front stage, then parsed and its result written
//   into the result queue, from whose head it is offered.
// Throughput: one byte per cycle, set by the combinational parser step and a
//   two-entry result queue; stalls only when that queue is full.
// Reset: synchronous active low; parser returns to the signature phase and
//   pass_payload to 1.
// ----------------------------------------------------------------------------
// gif_block_stream_parser
// GIF89a block stream parser: bytes in, field and block events out.
// ----------------------------------------------------------------------------
module gif_block_stream_parser #(
    parameter int QDEPTH = gbsp_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_event_res,
    output logic [23:0] o_value,
    output logic [7:0]  o_index,
    output logic [1:0]  o_block_kind,
    output logic [2:0]  o_disposal,
    output logic        o_user_input,
    output logic        o_transparency,
    output logic        o_interlace,
    output logic        o_has_control,
    output logic [2:0]  o_error_code
);

    logic r_pass;
    gbsp_pkg::t_item   in_item, f_item;
    gbsp_pkg::t_result c_res, q_res;
    logic f_valid, c_ready, c_push, q_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pass <= 1'b1;
        else if (i_cfg_we) r_pass <= i_cfg_data;
    end

    assign in_item = '{data_byte: i_data_byte, first_byte: i_first_byte,
                       last_byte: i_last_byte};

    gbsp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(in_item), .o_valid(f_valid), .i_ready(c_ready), .o_item(f_item)
    );

    gbsp_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pass_payload(r_pass),
        .i_valid(f_valid), .o_ready(c_ready), .i_item(f_item),
        .o_res_valid(c_push), .o_res(c_res), .i_q_room(q_room)
    );

    gbsp_outq #(.DEPTH(QDEPTH)) u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(c_push), .i_res(c_res),
        .o_room(q_room), .o_valid(o_valid), .i_ready(i_ready), .o_res(q_res)
    );

    assign o_event_res      = q_res.event_res;
    assign o_value          = q_res.value;
    assign o_index          = q_res.index;
    assign o_block_kind     = q_res.block_kind;
    assign o_disposal       = q_res.disposal;
    assign o_user_input     = q_res.user_input;
    assign o_transparency   = q_res.transparency;
    assign o_interlace      = q_res.interlace;
    assign o_has_control    = q_res.has_control;
    assign o_error_code     = q_res.error_code;

endmodule

### sv/gbsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbsp_front
// Input register stage: accept a byte transaction and hold it for the parser.
// ----------------------------------------------------------------------------
module gbsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gbsp_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output gbsp_pkg::t_item   o_item
);

    logic            r_valid;
    gbsp_pkg::t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

`ifndef SYNTH
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_item))
        else $error("front item lost while stalled");
`endif

endmodule

### sv/gbsp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbsp_core
// Parser state machine: one byte per cycle while the result queue has room, at most one result per byte.
// ----------------------------------------------------------------------------
module gbsp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_pass_payload,
    input  logic                i_valid,
    output logic                o_ready,
    input  gbsp_pkg::t_item     i_item,
    output logic                o_res_valid,
    output gbsp_pkg::t_result   o_res,
    input  logic                i_q_room
);

    gbsp_pkg::t_phase r_phase, n_phase, ph;
    logic [9:0]  r_pos, n_pos, pos;
    logic [7:0]  r_rem, n_rem;
    logic [23:0] r_acc, n_acc, acc;
    logic [8:0]  r_ent, n_ent, ent;
    logic [1:0]  r_kind, n_kind, kind;
    logic [7:0]  r_flags, n_flags, flags;
    logic        r_ctl, n_ctl, ctl;
    logic [7:0]  b;
    logic        fire, emit;
    gbsp_pkg::t_result res;
    logic [8:0]  ent_b;
    logic [10:0] ent3;
    logic [7:0]  pos_div3;
    logic [1:0]  pos_mod3;
    logic [1:0]  r_mod3;
    logic [7:0]  r_div3;

    assign o_ready = i_q_room;
    assign fire    = i_valid && i_q_room;
    assign b       = i_item.data_byte;

    always_comb begin
        ent_b = b[7] ? (9'd1 << ({1'b0, b[2:0]} + 4'd1)) : 9'd0;
        ent3  = {2'b00, ent} + {1'b0, ent, 1'b0};
        pos_div3 = i_item.first_byte ? 8'd0 : r_div3;
        pos_mod3 = i_item.first_byte ? 2'd0 : r_mod3;
    end

    always_comb begin
        ph    = i_item.first_byte ? gbsp_pkg::PH_HDR : r_phase;
        pos   = i_item.first_byte ? 10'd0 : r_pos;
        acc   = i_item.first_byte ? 24'd0 : r_acc;
        ent   = i_item.first_byte ? 9'd0 : r_ent;
        kind  = i_item.first_byte ? 2'd0 : r_kind;
        flags = i_item.first_byte ? 8'd0 : r_flags;
        ctl   = i_item.first_byte ? 1'b0 : r_ctl;
        n_rem = i_item.first_byte ? 8'd0 : r_rem;
        n_phase = ph;
        n_pos   = pos + 10'd1;
        n_acc   = acc;
        n_ent   = ent;
        n_kind  = kind;
        n_flags = flags;
        n_ctl   = ctl;
        emit    = 1'b0;
        res     = '0;
        unique case (ph)
            gbsp_pkg::PH_HDR: begin
                if (pos < 10'd3) begin
                    if ((pos == 10'd0 && b != 8'h47) || (pos == 10'd1 && b != 8'h49) ||
                        (pos == 10'd2 && b != 8'h46)) begin
                        emit = 1'b1; res.event_res = gbsp_pkg::EV_ERROR;
                        res.error_code = gbsp_pkg::ERR_HEADER; n_phase = gbsp_pkg::PH_DONE;
                    end
                end else if (pos < 10'd6) begin
                    n_acc = {acc[15:0], b};
                    if (pos == 10'd5) begin
                        emit = 1'b1; res.event_res = gbsp_pkg::EV_VERSION; res.value = n_acc;
                    end
                end else if (pos == 10'd6 || pos == 10'd8) begin
                    n_acc = {16'd0, b};
                end else if (pos == 10'd7 || pos == 10'd9) begin
                    emit = 1'b1;
                    res.event_res = (pos == 10'd7) ? gbsp_pkg::EV_SWIDTH : gbsp_pkg::EV_SHEIGHT;
                    res.value = acc | {8'd0, b, 8'd0};
                end else if (pos == 10'd10) begin
                    n_ent = ent_b;
                    emit = 1'b1; res.event_res = gbsp_pkg::EV_SFLAGS;
                    res.value = {15'd0, ent_b};
                    res.index = {5'd0, b[6:4]} + 8'd1;
                end else if (pos == 10'd11) begin
                    emit = 1'b1; res.event_res = gbsp_pkg::EV_BG; res.value = {16'd0, b};
                end else begin
                    emit = 1'b1; res.event_res = gbsp_pkg::EV_ASPECT; res.value = {16'd0, b};
                    n_phase = (ent != 9'd0) ? gbsp_pkg::PH_GCT : gbsp_pkg::PH_INTRO;
                    n_pos = 10'd0; n_acc = 24'd0;
                end
            end
            gbsp_pkg::PH_GCT, gbsp_pkg::PH_LCT: begin
                n_acc = {acc[15:0], b};
                if (pos_mod3 == 2'd2) begin
                    emit = 1'b1;
                    res.event_res = (ph == gbsp_pkg::PH_GCT) ? gbsp_pkg::EV_GCOLOUR
                                                            : gbsp_pkg::EV_LCOLOUR;
                    res.value = n_acc;
                    res.index = pos_div3;
                end
                if ({1'b0, pos} + 11'd1 >= ent3) begin
                    n_phase = (ph == gbsp_pkg::PH_GCT) ? gbsp_pkg::PH_INTRO
                                                       : gbsp_pkg::PH_MINCODE;
                    n_pos = 10'd0; n_acc = 24'd0;
                end
            end
            gbsp_pkg::PH_INTRO: begin
                n_pos = 10'd0; n_acc = 24'd0;
                if (b == 8'h3B) begin
                    emit = 1'b1; res.event_res = gbsp_pkg::EV_TRAILER;
                    n_phase = gbsp_pkg::PH_DONE; n_pos = pos + 10'd1; n_acc = acc;
                end else if (b == 8'h21) begin
                    n_phase = gbsp_pkg::PH_LABEL;
                end else if (b == 8'h2C) begin
                    n_phase = gbsp_pkg::PH_IMG;
                end else begin
                    emit = 1'b1; res.event_res = gbsp_pkg::EV_ERROR;
                    res.error_code = gbsp_pkg::ERR_UNKNOWN; n_phase = gbsp_pkg::PH_DONE;
                    n_pos = pos + 10'd1; n_acc = acc;
                end
            end
            gbsp_pkg::PH_LABEL: begin
                n_pos = 10'd0; n_acc = 24'd0;
                if (b == 8'hF9) n_phase = gbsp_pkg::PH_GC;
                else if (b == 8'h01) begin
                    n_kind = gbsp_pkg::KIND_TEXT; n_phase = gbsp_pkg::PH_SUBLEN;
                end else if (b == 8'hFE) begin
                    n_kind = gbsp_pkg::KIND_COMMENT; n_phase = gbsp_pkg::PH_SUBLEN;
                end else if (b == 8'hFF) n_phase = gbsp_pkg::PH_APPSIZE;
                else n_phase = gbsp_pkg::PH_SKIPLEN;
            end
            gbsp_pkg::PH_GC: begin
                if (pos == 10'd0) begin
                    if (b != 8'd4) begin
                        emit = 1'b1; res.event_res = gbsp_pkg::EV_ERROR;
                        res.error_code = gbsp_pkg::ERR_GCSIZE; n_phase = gbsp_pkg::PH_DONE;
                    end
                end else if (pos == 10'd1) begin
                    n_flags = b;
                end else if (pos == 10'd2) begin
                    n_acc = {16'd0, b};
                end else if (pos == 10'd3) begin
                    n_acc = acc | {8'd0, b, 8'd0};
                end else if (pos == 10'd4) begin
                    emit = 1'b1; res.event_res = gbsp_pkg::EV_GCTRL;
                    res.value = acc; res.index = b;
                    res.disposal = flags[4:2];
                    res.user_input = flags[1];
                    res.transparency = flags[0];
                    n_ctl = 1'b1;
                end else begin
                    n_phase = gbsp_pkg::PH_INTRO; n_pos = 10'd0; n_acc = 24'd0;
                end
            end
            gbsp_pkg::PH_APPSIZE: begin
                if (b != 8'd11) begin
                    emit = 1'b1; res.event_res = gbsp_pkg::EV_ERROR;
                    res.error_code = gbsp_pkg::ERR_APPSIZE; n_phase = gbsp_pkg::PH_DONE;
                end else begin
                    n_kind = gbsp_pkg::KIND_APP; n_phase = gbsp_pkg::PH_APPID;
                    n_pos = 10'd0; n_acc = 24'd0;
                end
            end
            gbsp_pkg::PH_APPID: begin
                emit = 1'b1; res.event_res = gbsp_pkg::EV_APPID;
                res.value = {16'd0, b}; res.index = pos[7:0];
                if (pos >= 10'd10) begin
                    n_phase = gbsp_pkg::PH_SUBLEN; n_pos = 10'd0; n_acc = 24'd0;
                end
            end
            gbsp_pkg::PH_SUBLEN, gbsp_pkg::PH_SKIPLEN: begin
                n_pos = 10'd0; n_acc = 24'd0;
                if (b == 8'd0) begin
                    if (ph == gbsp_pkg::PH_SUBLEN) begin
                        emit = 1'b1; res.event_res = gbsp_pkg::EV_BLKEND;
                        res.block_kind = kind;
                    end
                    n_phase = gbsp_pkg::PH_INTRO;
                end else begin
                    n_rem = b;
                    n_phase = (ph == gbsp_pkg::PH_SUBLEN) ? gbsp_pkg::PH_SUBDATA
                                                         : gbsp_pkg::PH_SKIPDATA;
                end
            end
            gbsp_pkg::PH_SUBDATA, gbsp_pkg::PH_SKIPDATA: begin
                if (ph == gbsp_pkg::PH_SUBDATA && i_pass_payload) begin
                    emit = 1'b1; res.event_res = gbsp_pkg::EV_PAYLOAD;
                    res.value = {16'd0, b}; res.block_kind = kind;
                end
                n_rem = n_rem - 8'd1;
                if (n_rem == 8'd0) begin
                    n_phase = (ph == gbsp_pkg::PH_SUBDATA) ? gbsp_pkg::PH_SUBLEN
                                                          : gbsp_pkg::PH_SKIPLEN;
                    n_pos = 10'd0; n_acc = 24'd0;
                end
            end
            gbsp_pkg::PH_IMG: begin
                if (pos < 10'd8) begin
                    if (!pos[0]) n_acc = {16'd0, b};
                    else begin
                        emit = 1'b1;
                        res.event_res = gbsp_pkg::EV_ILEFT + {2'b00, pos[3:1]};
                        res.value = acc | {8'd0, b, 8'd0};
                    end
                end else begin
                    n_ent = ent_b;
                    emit = 1'b1; res.event_res = gbsp_pkg::EV_IFLAGS;
                    res.value = {15'd0, ent_b};
                    res.interlace = b[6];
                    res.has_control = ctl;
                    n_ctl = 1'b0;
                    n_phase = (ent_b != 9'd0) ? gbsp_pkg::PH_LCT : gbsp_pkg::PH_MINCODE;
                    n_pos = 10'd0; n_acc = 24'd0;
                end
            end
            gbsp_pkg::PH_MINCODE: begin
                emit = 1'b1; res.event_res = gbsp_pkg::EV_MINCODE; res.value = {16'd0, b};
                n_kind = gbsp_pkg::KIND_IMAGE; n_phase = gbsp_pkg::PH_SUBLEN;
                n_pos = 10'd0; n_acc = 24'd0;
            end
            default: begin
                n_phase = gbsp_pkg::PH_DONE;
                n_pos = pos;
            end
        endcase
        if (ph == gbsp_pkg::PH_DONE) begin
            emit = 1'b0; n_pos = pos; n_acc = acc;
        end else if (i_item.last_byte && n_phase != gbsp_pkg::PH_DONE) begin
            emit = 1'b1; res = '0;
            res.event_res = gbsp_pkg::EV_ERROR; res.error_code = gbsp_pkg::ERR_TRUNC;
            n_phase = gbsp_pkg::PH_DONE;
        end
    end

    assign o_res_valid = fire && emit;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gbsp_pkg::PH_HDR;
            r_pos   <= 10'd0;
            r_rem   <= 8'd0;
            r_acc   <= 24'd0;
            r_ent   <= 9'd0;
            r_kind  <= 2'd0;
            r_flags <= 8'd0;
            r_ctl   <= 1'b0;
            r_mod3  <= 2'd0;
            r_div3  <= 8'd0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_rem   <= n_rem;
            r_acc   <= n_acc;
            r_ent   <= n_ent;
            r_kind  <= n_kind;
            r_flags <= n_flags;
            r_ctl   <= n_ctl;
            if (n_pos == 10'd0) begin
                r_mod3 <= 2'd0; r_div3 <= 8'd0;
            end else if (n_pos == pos + 10'd1) begin
                if (pos_mod3 == 2'd2) begin
                    r_mod3 <= 2'd0; r_div3 <= pos_div3 + 8'd1;
                end else begin
                    r_mod3 <= pos_mod3 + 2'd1; r_div3 <= pos_div3;
                end
            end
        end
    end

`ifndef SYNTH
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_phase == gbsp_pkg::PH_DONE && !i_item.first_byte |-> !o_res_valid)
        else $error("result after parse finished");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_item.last_byte |=> r_phase == gbsp_pkg::PH_DONE)
        else $error("last byte did not finish parse");
    a_mod3: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_mod3 != 2'd3)
        else $error("position remainder out of range");
`endif

endmodule

### sv/gbsp_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbsp_outq
// Result queue: short FIFO between the parser and the result channel.
// ----------------------------------------------------------------------------
module gbsp_outq #(
    parameter int DEPTH = gbsp_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gbsp_pkg::t_result  i_res,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output gbsp_pkg::t_result  o_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    gbsp_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic pop;

    assign o_valid = r_cnt != '0;
    assign o_room  = r_cnt != DEPTH[AW:0];
    assign pop     = o_valid && i_ready;
    assign o_res   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop)    r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + {{AW{1'b0}}, i_push} - {{AW{1'b0}}, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_res;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("push into full queue");
`endif

endmodule
